>>> hw/rtl/fpidx_pkg.sv
// Package: sizes, operation codes, payload and row types, and the bucket hash of the index.
package fpidx_pkg;

    // Table geometry. BUCKETS must be a power of two no larger than 1024, so that the
    // hash reduces by a mask and a slot number fits the 11-bit slot fields.
    localparam int BUCKETS    = 1024;
    localparam int BKT_W      = $clog2(BUCKETS);
    localparam int WAYS       = 2;
    localparam int SLOT_COUNT = WAYS * BUCKETS;
    localparam int SLOT_W     = 11;
    localparam int HASH_SHIFT = 8;

    // Reset value of the window register.
    localparam logic [31:0] WINDOW_RESET = 32'd65536;

    typedef logic [BKT_W-1:0] t_bkt;

    // Operation codes; codes five to seven are undefined and change nothing.
    typedef enum logic [2:0] {
        OP_LOOKUP     = 3'd0,
        OP_INSERT     = 3'd1,
        OP_INVALIDATE = 3'd2,
        OP_REASSIGN   = 3'd3,
        OP_REPLACE    = 3'd4
    } t_op;

    // Control flow of the top level.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // One input transaction.
    typedef struct packed {
        logic [2:0]        operation;
        logic [63:0]       fingerprint;
        logic [31:0]       current_serial;
        logic [31:0]       entry_serial;
        logic [15:0]       entry_offset;
        logic [15:0]       peer_offset;
        logic [15:0]       range_low;
        logic [15:0]       range_high;
        logic [SLOT_W-1:0] slot_index;
    } t_in_item;

    // One output transaction.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic [31:0]       hit_serial;
        logic [15:0]       hit_offset;
        logic              stored;
        logic [1:0]        slots_changed;
        logic [31:0]       stored_total;
        logic [31:0]       failed_total;
    } t_out_item;

    // One slot of a bucket; a serial of zero marks the slot empty.
    typedef struct packed {
        logic [63:0] fingerprint;
        logic [31:0] serial;
        logic [15:0] offset;
    } t_slot;

    // A bucket row holds both ways side by side.
    typedef t_slot [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    // Counter updates produced by the update logic.
    typedef struct packed {
        logic inc_stored;
        logic inc_failed;
    } t_cnt_inc;

    // Bucket of a fingerprint: ((fp >> 8) ^ fp) mod BUCKETS.
    function automatic t_bkt bucket_of(input logic [63:0] fp);
        logic [63:0] h;
        h = fp ^ (fp >> HASH_SHIFT);
        return h[BKT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/fpidx_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module fpidx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next enabled read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/fpidx_calc.sv
// Bucket update logic: evaluates one operation against a bucket row and forms the new row.
module fpidx_calc (
    input  fpidx_pkg::t_in_item  i_item,
    input  fpidx_pkg::t_bkt      i_bkt,
    input  fpidx_pkg::t_row      i_row,
    input  logic [31:0]          i_window,
    output fpidx_pkg::t_row      o_row,
    output fpidx_pkg::t_out_item o_res,
    output fpidx_pkg::t_cnt_inc  o_cnt
);

    logic [31:0]                  floor_v;
    logic [fpidx_pkg::WAYS-1:0]   live;
    logic [fpidx_pkg::WAYS-1:0]   stale;
    logic [fpidx_pkg::WAYS-1:0]   rmatch;
    logic [1:0]                   n_match;
    logic                         in_range;

    // Window floor saturates at zero.
    assign floor_v = (i_item.current_serial > i_window) ?
                     (i_item.current_serial - i_window) : 32'd0;

    // Per-way tests.
    always_comb begin
        for (int w = 0; w < fpidx_pkg::WAYS; w++) begin
            live[w]   = (i_row[w].serial != 32'd0) &&
                        (i_row[w].fingerprint == i_item.fingerprint) &&
                        (i_row[w].serial > floor_v);
            stale[w]  = (i_row[w].serial == 32'd0) || (i_row[w].serial < floor_v);
            rmatch[w] = (i_row[w].serial == i_item.current_serial) &&
                        (i_row[w].fingerprint == i_item.fingerprint) &&
                        (i_row[w].offset >= i_item.range_low) &&
                        (i_row[w].offset <= i_item.range_high);
        end
    end

    assign n_match  = {1'b0, rmatch[0]} + {1'b0, rmatch[1]};
    assign in_range = 32'(i_item.slot_index) < 32'(fpidx_pkg::SLOT_COUNT);

    // Operation decode and row modification.
    always_comb begin
        o_row = i_row;
        o_res = '0;
        o_cnt = '0;
        case (i_item.operation)
            fpidx_pkg::OP_LOOKUP: begin
                if (live[0]) begin
                    o_res.hit        = 1'b1;
                    o_res.hit_slot   = fpidx_pkg::SLOT_W'({i_bkt, 1'b0});
                    o_res.hit_serial = i_row[0].serial;
                    o_res.hit_offset = i_row[0].offset;
                end else if (live[1]) begin
                    o_res.hit        = 1'b1;
                    o_res.hit_slot   = fpidx_pkg::SLOT_W'({i_bkt, 1'b1});
                    o_res.hit_serial = i_row[1].serial;
                    o_res.hit_offset = i_row[1].offset;
                end
            end
            fpidx_pkg::OP_INSERT: begin
                if (stale[0]) begin
                    o_row[0].fingerprint = i_item.fingerprint;
                    o_row[0].serial      = i_item.entry_serial;
                    o_row[0].offset      = i_item.entry_offset;
                    o_res.stored         = 1'b1;
                    o_res.hit_slot       = fpidx_pkg::SLOT_W'({i_bkt, 1'b0});
                    o_cnt.inc_stored     = 1'b1;
                end else if (stale[1]) begin
                    o_row[1].fingerprint = i_item.fingerprint;
                    o_row[1].serial      = i_item.entry_serial;
                    o_row[1].offset      = i_item.entry_offset;
                    o_res.stored         = 1'b1;
                    o_res.hit_slot       = fpidx_pkg::SLOT_W'({i_bkt, 1'b1});
                    o_cnt.inc_stored     = 1'b1;
                end else begin
                    o_cnt.inc_failed = 1'b1;
                end
            end
            fpidx_pkg::OP_INVALIDATE: begin
                for (int w = 0; w < fpidx_pkg::WAYS; w++) begin
                    if (rmatch[w]) begin
                        o_row[w].serial = 32'd0;
                    end
                end
                o_res.slots_changed = n_match;
            end
            fpidx_pkg::OP_REASSIGN: begin
                // The new offset wraps at 16 bits.
                for (int w = 0; w < fpidx_pkg::WAYS; w++) begin
                    if (rmatch[w]) begin
                        o_row[w].serial = i_item.entry_serial;
                        o_row[w].offset = i_item.peer_offset - i_item.entry_offset +
                                          i_row[w].offset;
                    end
                end
                o_res.slots_changed = n_match;
            end
            fpidx_pkg::OP_REPLACE: begin
                if (in_range) begin
                    o_row[i_item.slot_index[0]].serial = i_item.entry_serial;
                    o_row[i_item.slot_index[0]].offset = i_item.entry_offset;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

>>> hw/rtl/fingerprint_index_two_way.sv
// Top level of the two-way fingerprint index: control, memory and result register.
//
// For each transaction the idle state reads the two-slot bucket row from the bucket memory,
// then the execute state compares, updates and writes the row back and loads the result
// register. The block then accepts the next transaction; a finished result may still wait
// in the result register while that happens, but the update cycle holds until the register
// is free. After reset a clearing pass writes every bucket row to empty, one row per cycle;
// input is stalled during that pass, while window writes are taken at any time. The window
// register resets to 65536.
module fingerprint_index_two_way (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [31:0]          i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fpidx_pkg::t_in_item  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fpidx_pkg::t_out_item o_out
);

    fpidx_pkg::t_state    r_state, n_state;
    fpidx_pkg::t_bkt      r_clr_addr;
    logic [31:0]          r_window;
    fpidx_pkg::t_in_item  r_item;
    fpidx_pkg::t_bkt      r_bkt, n_bkt;
    logic                 r_out_valid;
    fpidx_pkg::t_out_item r_out, n_out;
    logic [31:0]          r_stored_total, n_stored_total;
    logic [31:0]          r_failed_total, n_failed_total;

    logic                 in_accept;
    logic                 out_free;
    logic                 exec_done;
    logic                 ram_we;
    fpidx_pkg::t_bkt      ram_waddr;
    fpidx_pkg::t_row      ram_wdata;
    fpidx_pkg::t_row      ram_rdata;
    fpidx_pkg::t_row      calc_row;
    fpidx_pkg::t_out_item calc_res;
    fpidx_pkg::t_cnt_inc  calc_cnt;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_accept = i_in_valid && !o_in_stall;

    // Bucket to read: replace addresses a slot directly, all else hashes the fingerprint.
    always_comb begin
        if (i_in.operation == fpidx_pkg::OP_REPLACE) begin
            n_bkt = i_in.slot_index[fpidx_pkg::BKT_W:1];
        end else begin
            n_bkt = fpidx_pkg::bucket_of(i_in.fingerprint);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fpidx_pkg::ST_CLEAR: begin
                if (r_clr_addr == fpidx_pkg::BKT_W'(fpidx_pkg::BUCKETS - 1)) begin
                    n_state = fpidx_pkg::ST_IDLE;
                end
            end
            fpidx_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = fpidx_pkg::ST_EXEC;
                end
            end
            fpidx_pkg::ST_EXEC: begin
                if (out_free) begin
                    n_state = fpidx_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fpidx_pkg::ST_CLEAR;
            end
        endcase
    end

    // State outputs: stall, memory write selection and completion of the update.
    always_comb begin
        o_in_stall = 1'b1;
        exec_done  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_bkt;
        ram_wdata  = calc_row;
        case (r_state)
            fpidx_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            fpidx_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            fpidx_pkg::ST_EXEC: begin
                exec_done = out_free;
                ram_we    = out_free;
            end
            default: begin
            end
        endcase
    end

    // Running insert counters including the current transaction.
    assign n_stored_total = r_stored_total + {31'd0, calc_cnt.inc_stored};
    assign n_failed_total = r_failed_total + {31'd0, calc_cnt.inc_failed};

    // Result of the current transaction together with the updated totals.
    always_comb begin
        n_out              = calc_res;
        n_out.stored_total = n_stored_total;
        n_out.failed_total = n_failed_total;
    end

    // Bucket row memory.
    fpidx_ram #(
        .WIDTH (fpidx_pkg::ROW_W),
        .DEPTH (fpidx_pkg::BUCKETS)
    ) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (n_bkt),
        .o_rdata (ram_rdata)
    );

    // Compare and update logic.
    fpidx_calc u_calc (
        .i_item   (r_item),
        .i_bkt    (r_bkt),
        .i_row    (ram_rdata),
        .i_window (r_window),
        .o_row    (calc_row),
        .o_res    (calc_res),
        .o_cnt    (calc_cnt)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= fpidx_pkg::ST_CLEAR;
            r_clr_addr     <= '0;
            r_window       <= fpidx_pkg::WINDOW_RESET;
            r_out_valid    <= 1'b0;
            r_stored_total <= '0;
            r_failed_total <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == fpidx_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + fpidx_pkg::t_bkt'(1);
            end
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (exec_done) begin
                r_out_valid    <= 1'b1;
                r_stored_total <= n_stored_total;
                r_failed_total <= n_failed_total;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Transaction and result payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in;
            r_bkt  <= n_bkt;
        end
        if (exec_done) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> verif/fingerprint_index_two_way_tb.sv
// Self-checking testbench of the two-way fingerprint index with a shadow bucket table.
`timescale 1ns / 100ps

module fingerprint_index_two_way_tb;
    import fpidx_pkg::*;

    localparam logic [2:0] OP_FIRST_UNDEFINED = 3'd5;
    localparam int         RECENT_DEPTH       = 16;
    localparam int         POOL_SIZE          = 16;
    localparam int         PHASE_COUNT        = 8;
    localparam int         PHASE_ITEMS        = 131;

    // Shadow of the bucket table: predicts each outcome and checks the block against it.
    class bucket_table_shadow;
        logic [63:0] slot_fp [SLOT_COUNT];
        logic [31:0] slot_serial [SLOT_COUNT];
        logic [15:0] slot_offset [SLOT_COUNT];
        bit          fp_known [SLOT_COUNT];
        logic [31:0] window;
        logic [31:0] stored_cnt;
        logic [31:0] failed_cnt;
        t_out_item   expected_outcomes [$];
        int          errors;

        function new();
            for (int s = 0; s < SLOT_COUNT; s++) begin
                slot_fp[s]     = '0;
                slot_serial[s] = '0;
                slot_offset[s] = '0;
                fp_known[s]    = 1'b0;
            end
            window     = WINDOW_RESET;
            stored_cnt = '0;
            failed_cnt = '0;
            errors     = 0;
        endfunction

        function int unsigned slot_base(logic [63:0] fp);
            return 2 * int'(((fp >> HASH_SHIFT) ^ fp) % BUCKETS);
        endfunction

        function void set_window(logic [31:0] w);
            window = w;
        endfunction

        function int outstanding();
            return expected_outcomes.size();
        endfunction

        // Apply one accepted transaction to the shadow table and queue its outcome.
        function void note_request(t_in_item it);
            t_out_item   r;
            logic [31:0] floor_v;
            int unsigned base;
            int unsigned s;
            r = '0;
            floor_v = (it.current_serial > window) ? it.current_serial - window : 32'd0;
            base = slot_base(it.fingerprint);
            case (it.operation)
                OP_LOOKUP: begin
                    for (int w = 0; w < WAYS; w++) begin
                        s = base + w;
                        if (!r.hit && slot_serial[s] != 0 && slot_fp[s] == it.fingerprint
                                && slot_serial[s] > floor_v) begin
                            r.hit        = 1'b1;
                            r.hit_slot   = SLOT_W'(s);
                            r.hit_serial = slot_serial[s];
                            r.hit_offset = slot_offset[s];
                        end
                    end
                end
                OP_INSERT: begin
                    // First empty or stale way wins; a serial equal to the floor is kept.
                    for (int w = 0; w < WAYS; w++) begin
                        s = base + w;
                        if (!r.stored && (slot_serial[s] == 0 || slot_serial[s] < floor_v)) begin
                            slot_fp[s]     = it.fingerprint;
                            slot_serial[s] = it.entry_serial;
                            slot_offset[s] = it.entry_offset;
                            fp_known[s]    = 1'b1;
                            r.stored       = 1'b1;
                            r.hit_slot     = SLOT_W'(s);
                            stored_cnt     = stored_cnt + 32'd1;
                        end
                    end
                    if (!r.stored) begin
                        failed_cnt = failed_cnt + 32'd1;
                    end
                end
                OP_INVALIDATE, OP_REASSIGN: begin
                    for (int w = 0; w < WAYS; w++) begin
                        s = base + w;
                        if (slot_serial[s] == it.current_serial
                                && slot_fp[s] == it.fingerprint
                                && slot_offset[s] >= it.range_low
                                && slot_offset[s] <= it.range_high) begin
                            if (it.operation == OP_REASSIGN) begin
                                slot_serial[s] = it.entry_serial;
                                slot_offset[s] = it.peer_offset - it.entry_offset
                                                 + slot_offset[s];
                            end else begin
                                slot_serial[s] = '0;
                            end
                            r.slots_changed = r.slots_changed + 2'd1;
                        end
                    end
                end
                OP_REPLACE: begin
                    if (it.slot_index < SLOT_COUNT) begin
                        slot_serial[it.slot_index] = it.entry_serial;
                        slot_offset[it.slot_index] = it.entry_offset;
                    end
                end
                default: begin
                end
            endcase
            r.stored_total = stored_cnt;
            r.failed_total = failed_cnt;
            expected_outcomes.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted outcome with the oldest prediction.
        function void check_outcome(t_out_item got);
            t_out_item want;
            if (expected_outcomes.size() == 0) begin
                $display("%0t: outcome %0h arrived with no transaction pending", $time, got);
                errors++;
                return;
            end
            want = expected_outcomes.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("hit_slot", want.hit_slot, got.hit_slot);
            compare_field("hit_serial", want.hit_serial, got.hit_serial);
            compare_field("hit_offset", want.hit_offset, got.hit_offset);
            compare_field("stored", want.stored, got.stored);
            compare_field("slots_changed", want.slots_changed, got.slots_changed);
            compare_field("stored_total", want.stored_total, got.stored_total);
            compare_field("failed_total", want.failed_total, got.failed_total);
        endfunction
    endclass

    typedef struct {
        logic [63:0] fp;
        logic [31:0] serial;
        logic [15:0] offset;
    } t_entry_note;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    t_in_item    in_item     = '0;
    logic        out_stall   = 1'b0;
    logic        in_stall;
    logic        out_valid;
    t_out_item   out_item;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic [31:0] serial_now = '0;
    logic [63:0] fp_pool [POOL_SIZE];
    t_entry_note recent [$];

    bucket_table_shadow board = new();

    fingerprint_index_two_way u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in          (in_item),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out         (out_item)
    );

    always #10 clk = ~clk;

    // Result side: check each accepted transaction, then pick the next stall.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            board.check_outcome(out_item);
        end
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Fingerprint with a chosen bucket: each low bit is solved against the bit eight above.
    function automatic logic [63:0] fp_in_bucket(input int unsigned bkt,
                                                 input logic [63:0] seed);
        logic [63:0] fp;
        fp = seed;
        for (int i = BKT_W - 1; i >= 0; i--) begin
            fp[i] = bkt[i] ^ fp[i + HASH_SHIFT];
        end
        return fp;
    endfunction

    function automatic t_in_item make_item(input logic [2:0] op, input logic [63:0] fp,
                                           input logic [31:0] cur, input logic [31:0] eser,
                                           input logic [15:0] eoff, input logic [15:0] moff,
                                           input logic [15:0] lo, input logic [15:0] hi,
                                           input logic [SLOT_W-1:0] sidx);
        t_in_item it;
        it.operation      = op;
        it.fingerprint    = fp;
        it.current_serial = cur;
        it.entry_serial   = eser;
        it.entry_offset   = eoff;
        it.peer_offset    = moff;
        it.range_low      = lo;
        it.range_high     = hi;
        it.slot_index     = sidx;
        return it;
    endfunction

    function automatic t_in_item random_fields();
        return make_item(3'($urandom_range(7)), {$urandom, $urandom}, $urandom, $urandom,
                         16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         SLOT_W'($urandom));
    endfunction

    function automatic void remember(input logic [63:0] fp, input logic [31:0] serial,
                                     input logic [15:0] offset);
        t_entry_note n;
        n.fp     = fp;
        n.serial = serial;
        n.offset = offset;
        recent.push_back(n);
        if (recent.size() > RECENT_DEPTH) begin
            void'(recent.pop_front());
        end
    endfunction

    // Mostly well-formed transactions on a few crowded buckets, the rest pure noise.
    function automatic t_in_item next_random_item();
        t_in_item    it;
        t_entry_note rec;
        int unsigned pick;
        int unsigned mode;
        int unsigned base;
        it = random_fields();
        serial_now = serial_now + 32'($urandom_range(2));
        pick = $urandom_range(99);
        if (recent.size() == 0 && pick >= 30 && pick < 87) begin
            pick = 0;
        end
        if (recent.size() != 0) begin
            rec = recent[$urandom_range(recent.size() - 1)];
        end
        if (pick < 30) begin
            it.operation = OP_INSERT;
            if ($urandom_range(99) < 80) begin
                it.fingerprint = fp_pool[$urandom_range(POOL_SIZE - 1)];
            end
            it.current_serial = serial_now;
            mode = $urandom_range(99);
            it.entry_serial = (mode < 85) ? serial_now : (mode < 90) ? 32'd0 : $urandom;
            remember(it.fingerprint, it.entry_serial, it.entry_offset);
        end else if (pick < 55) begin
            it.operation = OP_LOOKUP;
            it.fingerprint = ($urandom_range(99) < 70) ? rec.fp
                                                       : fp_pool[$urandom_range(POOL_SIZE - 1)];
            it.current_serial = serial_now;
        end else if (pick < 79) begin
            it.operation = (pick < 67) ? OP_INVALIDATE : OP_REASSIGN;
            it.fingerprint = ($urandom_range(99) < 90) ? rec.fp
                                                       : fp_pool[$urandom_range(POOL_SIZE - 1)];
            it.current_serial = rec.serial;
            case ($urandom_range(3))
                0: begin
                    it.range_low  = 16'h0000;
                    it.range_high = 16'hFFFF;
                end
                1: begin
                    it.range_low  = rec.offset;
                    it.range_high = rec.offset;
                end
                2: begin
                    it.range_low  = (rec.offset >= 16'd4) ? rec.offset - 16'd4 : 16'h0000;
                    it.range_high = (rec.offset <= 16'hFFFB) ? rec.offset + 16'd4 : 16'hFFFF;
                end
                default: begin
                end
            endcase
            if (it.operation == OP_REASSIGN) begin
                it.entry_serial = ($urandom_range(99) < 80) ? serial_now : $urandom;
                remember(it.fingerprint, it.entry_serial,
                         it.peer_offset - it.entry_offset + rec.offset);
            end
        end else if (pick < 87) begin
            it.operation = OP_REPLACE;
            it.slot_index = SLOT_W'(board.slot_base(rec.fp) + $urandom_range(1));
            if (!board.fp_known[it.slot_index]) begin
                it.slot_index[0] = ~it.slot_index[0];
            end
            mode = $urandom_range(99);
            it.entry_serial = (mode < 80) ? serial_now : (mode < 90) ? 32'd0 : $urandom;
        end
        // Keep replaces and zero-serial matches off slots whose fingerprint was never written.
        if (it.operation == OP_REPLACE && !board.fp_known[it.slot_index]) begin
            it.operation = OP_LOOKUP;
        end
        base = board.slot_base(it.fingerprint);
        if ((it.operation == OP_INVALIDATE || it.operation == OP_REASSIGN)
                && it.current_serial == 0
                && !(board.fp_known[base] && board.fp_known[base + 1])) begin
            it.current_serial = 32'd1;
        end
        return it;
    endfunction

    // Present one transaction after an optional random gap and hold it until accepted.
    task automatic send_request(input t_in_item it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall !== 1'b0);
        board.note_request(it);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.outstanding() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_window(input logic [31:0] w);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_window(w);
    endtask

    // Run limit.
    initial begin
        #5_000_000;
        $display("[fingerprint_index_two_way] ERROR");
        $finish;
    end

    initial begin
        t_in_item    it;
        logic [63:0] fa;
        logic [63:0] fz;
        logic [63:0] fc;
        logic [63:0] fe;
        int unsigned hot [4];
        logic [31:0] w_next;

        fa = 64'h0;
        fz = '1;
        fc = fp_in_bucket(0, 64'h0123_4567_89AB_CDEF);
        fe = fp_in_bucket(BUCKETS - 1, 64'hFEDC_BA98_7654_3210);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset window: bucket 0 and the last bucket.
        send_request(make_item(OP_LOOKUP, fa, 5, 0, 0, 0, 0, 0, 0));
        send_request(make_item(OP_INSERT, fa, 100, 100, 0, 0, 0, 0, 0));
        send_request(make_item(OP_INSERT, fz, 100, '1, 16'hFFFF, 0, 0, 0, 0));
        // Both ways taken: the insert fails.
        send_request(make_item(OP_INSERT, fc, 101, 101, 7, 0, 0, 0, 0));
        send_request(make_item(OP_LOOKUP, fa, 101, 0, 0, 0, 0, 0, 0));
        send_request(make_item(OP_LOOKUP, fz, '1, 0, 0, 0, 0, 0, 0));
        // Serial equal to the floor: neither a hit nor stale.
        send_request(make_item(OP_LOOKUP, fa, 65636, 0, 0, 0, 0, 0, 0));
        send_request(make_item(OP_LOOKUP, fa, 65635, 0, 0, 0, 0, 0, 0));
        send_request(make_item(OP_INSERT, fc, 65636, 65636, 7, 0, 0, 0, 0));
        send_request(make_item(OP_INSERT, fc, 65637, 65637, 7, 0, 0, 0, 0));
        send_request(make_item(OP_INVALIDATE, fz, '1, 0, 0, 0, 0, 16'hFFFF, 0));
        send_request(make_item(OP_INSERT, fa, 65637, 7, 16'h1234, 0, 0, 0, 0));
        send_request(make_item(OP_REASSIGN, fa, 7, 9, 16'h0010, 0, 16'h1234, 16'h1234, 0));
        // Offset shift that wraps at 16 bits.
        send_request(make_item(OP_REASSIGN, fa, 9, 9, 16'hFFFF, 0, 0, 16'hFFFF, 0));
        // Empty range, then a range that misses the stored offset.
        send_request(make_item(OP_INVALIDATE, fa, 9, 0, 0, 0, 5, 4, 0));
        send_request(make_item(OP_INVALIDATE, fa, 9, 0, 0, 0, 16'h1226, 16'hFFFF, 0));
        send_request(make_item(OP_REPLACE, 0, 0, 0, 5, 0, 0, 0, 0));
        // Match serial of zero on a bucket whose fingerprints are both written.
        send_request(make_item(OP_INVALIDATE, fc, 0, 0, 0, 0, 0, 16'hFFFF, 0));
        send_request(make_item(OP_INSERT, fe, 50, 50, 100, 0, 0, 0, 0));
        send_request(make_item(OP_INSERT, fe, 50, 50, 200, 0, 0, 0, 0));
        // Both ways matched at once.
        send_request(make_item(OP_REASSIGN, fe, 50, 55, 0, 1, 0, 16'hFFFF, 0));
        send_request(make_item(OP_REPLACE, 0, 0, 60, 16'hABCD, 0, 0, 0, SLOT_COUNT - 1));
        send_request(make_item(OP_LOOKUP, fe, 60, 0, 0, 0, 0, 0, 0));
        // Undefined operation codes.
        for (int k = 0; k < 3; k++) begin
            it = random_fields();
            it.operation = OP_FIRST_UNDEFINED + 3'(k);
            send_request(it);
        end

        // Random phases, each with its own window, serial range and idle pattern.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain_results();
            case (p)
                0: w_next = 32'd1;
                1: w_next = 32'hFFFF_FFFF;
                2: w_next = 32'd4;
                3: w_next = 32'd20;
                4: w_next = $urandom_range(200, 1);
                5: w_next = 32'd1000;
                6: w_next = ($urandom == 0) ? 32'd1 : $urandom;
                default: w_next = WINDOW_RESET;
            endcase
            write_window(w_next);
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 51;
                end
                default: begin
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                end
            endcase
            case (p % 3)
                0: serial_now = $urandom_range(50);
                1: serial_now = 32'hFFFF_FFFF - $urandom_range(300);
                default: serial_now = $urandom;
            endcase
            // Four crowded buckets per phase, the table edges among them in the first.
            for (int j = 0; j < 4; j++) begin
                hot[j] = $urandom_range(BUCKETS - 1);
            end
            if (p == 0) begin
                hot[0] = 0;
                hot[1] = BUCKETS - 1;
            end
            for (int j = 0; j < POOL_SIZE; j++) begin
                fp_pool[j] = fp_in_bucket(hot[j % 4], {$urandom, $urandom});
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(next_random_item());
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (board.errors == 0) begin
            $display("[fingerprint_index_two_way] OK");
        end else begin
            $display("[fingerprint_index_two_way] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/fpidx_pkg.sv
hw/rtl/fpidx_ram.sv
hw/rtl/fpidx_calc.sv
hw/rtl/fingerprint_index_two_way.sv
verif/fingerprint_index_two_way_tb.sv
